// File: rtl/core/slxfr_pkg.sv
// ============================================================================
// slxfr_pkg - shared types for the start/length/xor frame receiver
// Result descriptors, payload store request and receive phase encoding.
// ============================================================================
package slxfr_pkg;

    // reset value of the start marker register
    localparam logic [7:0] START_MARKER_RST = 8'hAA;

    // result kinds
    localparam logic RES_EOF  = 1'b0;
    localparam logic RES_READ = 1'b1;

    // input transaction kinds
    localparam logic KIND_RX   = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // receive phase
    typedef enum logic [1:0] {
        PH_HUNT,
        PH_CMD,
        PH_LEN,
        PH_BODY
    } phase_t;

    // result waiting for the payload store read data
    typedef struct packed {
        logic       result_kind;
        logic       frame_good;
        logic [7:0] command_code;
        logic [7:0] payload_length;
        logic       read_hit;
    } pend_t;

    // finished result
    typedef struct packed {
        logic       result_kind;
        logic       frame_good;
        logic [7:0] command_code;
        logic [7:0] payload_length;
        logic [7:0] read_data;
    } res_t;

    // payload store access request
    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_addr;
        logic [7:0] wr_data;
        logic       rd_en;
        logic [7:0] rd_addr;
    } ram_req_t;

endpackage

// File: rtl/core/slxfr_ram.sv
// ============================================================================
// slxfr_ram - generic single-clock ram
// One write port and one read port, read data registered on read enable.
// ============================================================================
module slxfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// File: rtl/core/slxfr_ctrl.sv
// ============================================================================
// slxfr_ctrl - frame parser and payload store access
// Tracks the receive phase and running xor, drives the payload store and
// holds one pending result while its store read completes.
// ============================================================================
module slxfr_ctrl #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic                in_acc,
    input  logic                in_kind,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          read_index,
    input  logic                p1_move,
    output slxfr_pkg::ram_req_t ram_req,
    output logic                p1_valid,
    output slxfr_pkg::pend_t    p1_pend
);

    slxfr_pkg::phase_t phase_reg, phase_next;
    logic [7:0] marker_reg, marker_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] cnt_reg, cnt_next;
    logic       ready_reg, ready_next;
    logic       p1_valid_reg, p1_valid_next;
    slxfr_pkg::pend_t p1_reg, p1_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= slxfr_pkg::PH_HUNT;
            marker_reg   <= slxfr_pkg::START_MARKER_RST;
            cmd_reg      <= '0;
            len_reg      <= '0;
            xor_reg      <= '0;
            cnt_reg      <= '0;
            ready_reg    <= 1'b0;
            p1_valid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            marker_reg   <= marker_next;
            cmd_reg      <= cmd_next;
            len_reg      <= len_next;
            xor_reg      <= xor_next;
            cnt_reg      <= cnt_next;
            ready_reg    <= ready_next;
            p1_valid_reg <= p1_valid_next;
        end
        p1_reg <= p1_next;
    end

    always_comb begin
        phase_next    = phase_reg;
        marker_next   = cfg_wr_en ? cfg_wr_data : marker_reg;
        cmd_next      = cmd_reg;
        len_next      = len_reg;
        xor_next      = xor_reg;
        cnt_next      = cnt_reg;
        ready_next    = ready_reg;
        p1_valid_next = p1_move ? 1'b0 : p1_valid_reg;
        p1_next       = p1_reg;
        ram_req       = '0;
        ram_req.wr_data = rx_byte;
        ram_req.wr_addr = cnt_reg;
        ram_req.rd_addr = read_index;

        if (in_acc) begin
            if (in_kind == slxfr_pkg::KIND_READ) begin
                ram_req.rd_en          = 1'b1;
                p1_valid_next          = 1'b1;
                p1_next                = '0;
                p1_next.result_kind    = slxfr_pkg::RES_READ;
                p1_next.read_hit       = ready_reg && (read_index < len_reg) &&
                                         ({1'b0, read_index} < 9'(MAX_PAYLOAD));
            end else begin
                case (phase_reg)
                    slxfr_pkg::PH_HUNT: begin
                        if (rx_byte == marker_reg) begin
                            xor_next   = rx_byte;
                            ready_next = 1'b0;
                            phase_next = slxfr_pkg::PH_CMD;
                        end
                    end
                    slxfr_pkg::PH_CMD: begin
                        cmd_next   = rx_byte;
                        xor_next   = xor_reg ^ rx_byte;
                        phase_next = slxfr_pkg::PH_LEN;
                    end
                    slxfr_pkg::PH_LEN: begin
                        len_next   = rx_byte;
                        xor_next   = xor_reg ^ rx_byte;
                        cnt_next   = '0;
                        phase_next = slxfr_pkg::PH_BODY;
                    end
                    slxfr_pkg::PH_BODY: begin
                        if (cnt_reg < len_reg) begin
                            // positions beyond the store still enter the xor
                            ram_req.wr_en = ({1'b0, cnt_reg} < 9'(MAX_PAYLOAD));
                            xor_next      = xor_reg ^ rx_byte;
                            cnt_next      = cnt_reg + 8'd1;
                        end else begin
                            // checksum byte
                            ready_next             = (xor_reg == rx_byte);
                            phase_next             = slxfr_pkg::PH_HUNT;
                            p1_valid_next          = 1'b1;
                            p1_next                = '0;
                            p1_next.result_kind    = slxfr_pkg::RES_EOF;
                            p1_next.frame_good     = (xor_reg == rx_byte);
                            p1_next.command_code   = cmd_reg;
                            p1_next.payload_length = len_reg;
                        end
                    end
                    default: begin
                        phase_next = slxfr_pkg::PH_HUNT;
                    end
                endcase
            end
        end
    end

    assign p1_valid = p1_valid_reg;
    assign p1_pend  = p1_reg;

`ifndef ASSERT_OFF
    // payload writes only happen while no good frame is held
    a_wr_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.wr_en |-> !ready_reg)
        else $error("payload write while a good frame is held");

    // a new transaction never lands on a pending result that cannot leave
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && p1_valid_reg) |-> p1_move)
        else $error("pending result overwritten");
`endif

endmodule

// File: rtl/core/slxfr_outq.sv
// ============================================================================
// slxfr_outq - result register with skid stage
// Joins the pending result with the store read data and buffers two results.
// ============================================================================
module slxfr_outq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             p1_valid,
    input  slxfr_pkg::pend_t p1_pend,
    input  logic [7:0]       rd_data,
    input  logic             m_ready,
    output logic             p1_move,
    output logic             out_valid,
    output slxfr_pkg::res_t  out_res,
    output logic             skid_full
);

    logic            out_valid_reg, out_valid_next;
    logic            skid_valid_reg, skid_valid_next;
    slxfr_pkg::res_t out_reg, out_next;
    slxfr_pkg::res_t skid_reg, skid_next;
    slxfr_pkg::res_t p1_res;
    logic            pop;

    always_comb begin
        p1_res.result_kind    = p1_pend.result_kind;
        p1_res.frame_good     = p1_pend.frame_good;
        p1_res.command_code   = p1_pend.command_code;
        p1_res.payload_length = p1_pend.payload_length;
        p1_res.read_data      = p1_pend.read_hit ? rd_data : 8'd0;
    end

    assign pop = out_valid_reg && m_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (pop) begin
            out_valid_next  = skid_valid_reg;
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
        p1_move = p1_valid && !skid_valid_next;
        if (p1_move) begin
            if (!out_valid_next) begin
                out_valid_next = 1'b1;
                out_next       = p1_res;
            end else begin
                skid_valid_next = 1'b1;
                skid_next       = p1_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign skid_full = skid_valid_reg;

`ifndef ASSERT_OFF
    // the skid stage only fills behind a held output
    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result ahead of the output register");

    // a pending result stays back only when both slots are full and stalled
    a_hold_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid && !p1_move) |-> (skid_valid_reg && out_valid_reg && !m_ready))
        else $error("pending result held with room in the queue");
`endif

endmodule

// File: rtl/core/start_length_xor_frame_receiver.sv
// ============================================================================
// start_length_xor_frame_receiver - start/length/xor framed byte receiver
// Hunts for the start marker, takes command, length, payload and checksum,
// reports each frame and serves reads of the stored payload.
// ============================================================================
//
// channel  dir  handshake          tdata                               tuser
// s_       in   s_tvalid/s_tready  rx_byte, read_index                 kind
// m_       out  m_tvalid/m_tready  good, command, length, read data    result_kind
// cfg_     in   cfg_wr_en          start marker                        -
//
// one transaction accepted per cycle while s_tready is high; a result passes the pending
// register, joined with the registered read of the payload store, then the output register
// s_tready drops only when both the output register and the skid stage hold
// results, so bytes keep flowing while a single result waits
// synchronous active-low reset; the payload store is not cleared, entries are
// only read back once a good frame has written them
// a stored byte is read only after its write, since the
// checksum byte sits between the last payload write and any read hit
//
module start_length_xor_frame_receiver #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic        aclk,
    input  logic        aresetn,

    // start marker register
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,

    // input transactions
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [15:8] read_index
    input  logic        s_tuser,   // [0] kind

    // result transactions
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] frame_good, [8:1] command_code,
                                   // [16:9] payload_length, [24:17] read_data, zero pad
    output logic        m_tuser    // [0] result_kind
);

    // payload store address width
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic                in_acc;
    slxfr_pkg::ram_req_t ram_req;
    logic [7:0]          ram_rd_data;
    logic                p1_valid;
    slxfr_pkg::pend_t    p1_pend;
    logic                p1_move;
    logic                skid_full;
    slxfr_pkg::res_t     out_res;

    // accept whenever the skid stage is free
    assign s_tready = !skid_full;
    assign in_acc   = s_tvalid && s_tready;

    // frame parsing, running xor and store addressing
    slxfr_ctrl #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_acc      (in_acc),
        .in_kind     (s_tuser),
        .rx_byte     (s_tdata[7:0]),
        .read_index  (s_tdata[15:8]),
        .p1_move     (p1_move),
        .ram_req     (ram_req),
        .p1_valid    (p1_valid),
        .p1_pend     (p1_pend)
    );

    // payload store
    slxfr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr[AW-1:0]),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // output register and skid stage
    slxfr_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .p1_valid  (p1_valid),
        .p1_pend   (p1_pend),
        .rd_data   (ram_rd_data),
        .m_ready   (m_tready),
        .p1_move   (p1_move),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .skid_full (skid_full)
    );

    // pack the result fields, lowest bit first
    assign m_tdata = {7'd0, out_res.read_data, out_res.payload_length,
                      out_res.command_code, out_res.frame_good};
    assign m_tuser = out_res.result_kind;

endmodule
